@@ sv/weighted_correlation_clamped_assert.svh @@
// assertion macros for the weighted correlation block
`ifndef WEIGHTED_CORRELATION_CLAMPED_ASSERT_SVH
`define WEIGHTED_CORRELATION_CLAMPED_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define WCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define WCC_ASSERT_NOW(lbl, ante, cons, msg)
`define WCC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/wcorr_pkg.sv @@
// shared constants and types for the weighted correlation block
package wcorr_pkg;
  localparam int MAX_PAIRS  = 1024;
  localparam int ADDR_W     = $clog2(MAX_PAIRS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int TERM_SHIFT = 10;
  localparam logic [14:0] CLAMP_Q14 = 15'd16367;
  localparam logic [21:0] CLAMP_RAW = 22'd32734;

  typedef enum logic [14:0] {
    S_LOAD   = 15'b000000000000001,
    S_CHK    = 15'b000000000000010,
    S_DIV    = 15'b000000000000100,
    S_DIVEND = 15'b000000000001000,
    S_RD     = 15'b000000000010000,
    S_RDW    = 15'b000000000100000,
    S_MA     = 15'b000000001000000,
    S_MB     = 15'b000000010000000,
    S_MC     = 15'b000000100000000,
    S_MD     = 15'b000001000000000,
    S_FIN    = 15'b000010000000000,
    S_NRM    = 15'b000100000000000,
    S_SQ     = 15'b001000000000000,
    S_DEN    = 15'b010000000000000,
    S_OUT    = 15'b100000000000000
  } state_t;

  typedef enum logic [1:0] {
    PH_M1  = 2'd0,
    PH_M2  = 2'd1,
    PH_COR = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    T_S11 = 2'd0,
    T_S22 = 2'd1,
    T_S12 = 2'd2
  } term_t;
endpackage

@@ sv/weighted_correlation_clamped.sv @@
// weighted correlation of sample pairs: store, two-pass sums, root and divide
// Pairs load at one item per cycle into a 1024-entry store while the weighted
// sums build up; a pair that arrives with the store full is dropped, though its
// last-pair mark still ends the set. After the last pair the block is busy:
// two mean divisions, a second pass over every stored pair through the one
// shared multiplier, two square roots, and a long division of the cross sum
// by the product of the roots, its length set by their normalizing shifts
// (at most 30 each). The result is held until taken; the next set then
// loads. Sets with too few counted pairs go straight to the result.
`include "weighted_correlation_clamped_assert.svh"
module weighted_correlation_clamped
  import wcorr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_first_value,
  input  logic signed [15:0] in_second_value,
  input  logic        [15:0] in_sample_weight,
  input  logic               in_last_pair,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] out_correlation,
  output logic               out_result_valid
);

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  term_t  term_r, term_nxt;

  logic [47:0] mem [MAX_PAIRS];
  logic [47:0] rd_data_r;

  logic [CNT_W-1:0] cnt_r, cnt_nxt, used_r, used_nxt, idx_r, idx_nxt;
  logic [26:0] wsum_r, wsum_nxt;
  logic signed [42:0] s1_r, s1_nxt, s2_r, s2_nxt;

  logic signed [20:0] m1_r, m1_nxt, m2_r, m2_nxt;
  logic signed [21:0] d1_r, d1_nxt, d2_r, d2_nxt;
  logic [15:0] w_r, w_nxt;
  logic signed [43:0] p_r, p_nxt;
  logic [37:0] lo_r, lo_nxt;
  logic signed [59:0] t_r, t_nxt;
  logic signed [59:0] s11_r, s11_nxt, s22_r, s22_nxt, s12_r, s12_nxt;

  logic [61:0] sq_v_r, sq_v_nxt, sq_res_r, sq_res_nxt;
  logic [60:0] sq_bit_r, sq_bit_nxt;
  logic [4:0]  sq_k_r, sq_k_nxt, ka_r, ka_nxt, kb_r, kb_nxt;
  logic        sq_sel_r, sq_sel_nxt;
  logic [30:0] sq1_r, sq1_nxt, sq2_r, sq2_nxt;

  logic [63:0] dvd_r, dvd_nxt, rem_r, rem_nxt;
  logic [61:0] den_r, den_nxt;
  logic [21:0] q_r, q_nxt;
  logic        sat_r, sat_nxt, neg_r, neg_nxt;
  logic [7:0]  dcnt_r, dcnt_nxt;

  logic signed [14:0] corr_r, corr_nxt;
  logic        rvalid_r, rvalid_nxt;

  logic               accept, store_ok;
  logic signed [32:0] wp1, wp2;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [48:0] mn1, mn2;
  logic [48:0]        mag1, mag2;
  logic [63:0]        rem_sh;
  logic               dge;
  logic [62:0]        sq_sum;
  logic               sq_ge;
  logic [22:0]        mq;
  logic signed [22:0] mval;
  logic [59:0]        s12_mag;
  logic [6:0]         e_ext;
  logic [22:0]        qr;
  logic [14:0]        cmag;

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = (state_r == S_OUT);
  assign out_correlation  = corr_r;
  assign out_result_valid = rvalid_r;
  assign accept   = in_valid && in_ready;
  assign store_ok = !cnt_r[CNT_W-1];

  assign wp1 = $signed({1'b0, in_sample_weight}) * in_first_value;
  assign wp2 = $signed({1'b0, in_sample_weight}) * in_second_value;

  assign mn1  = {s1_r[42], s1_r, 5'b0} + $signed({22'b0, wsum_r});
  assign mn2  = {s2_r[42], s2_r, 5'b0} + $signed({22'b0, wsum_r});
  assign mag1 = mn1[48] ? 49'(-mn1) : 49'(mn1);
  assign mag2 = mn2[48] ? 49'(-mn2) : 49'(mn2);

  assign prod = mul_a * mul_b;

  assign rem_sh = {rem_r[62:0], dvd_r[63]};
  assign dge    = rem_sh >= {2'b0, den_r};

  assign sq_sum = {1'b0, sq_res_r} + {2'b0, sq_bit_r};
  assign sq_ge  = {1'b0, sq_v_r} >= sq_sum;

  assign mq   = {1'b0, q_r} + {22'b0, (neg_r && (rem_r != '0))};
  assign mval = neg_r ? -$signed(mq) : $signed(mq);

  assign s12_mag = s12_r[59] ? 60'(-s12_r) : 60'(s12_r);
  assign e_ext   = {2'b0, ka_r} + {2'b0, kb_r} + 7'd15;
  assign qr      = ({1'b0, q_r} + 23'd1) >> 1;
  assign cmag    = (sat_r || (q_r >= CLAMP_RAW)) ? CLAMP_Q14 : qr[14:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MA: begin
        mul_a = 33'((term_r == T_S22) ? d2_r : d1_r);
        mul_b = 33'((term_r == T_S11) ? d1_r : d2_r);
      end
      S_MB: begin
        mul_a = $signed({11'b0, p_r[21:0]});
        mul_b = $signed({17'b0, w_r});
      end
      S_MC: begin
        mul_a = 33'($signed(p_r[43:22]));
        mul_b = $signed({17'b0, w_r});
      end
      S_DEN: begin
        mul_a = $signed({2'b0, sq1_r});
        mul_b = $signed({2'b0, sq2_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    term_nxt  = term_r;
    cnt_nxt   = cnt_r;
    used_nxt  = used_r;
    idx_nxt   = idx_r;
    wsum_nxt  = wsum_r;
    s1_nxt    = s1_r;
    s2_nxt    = s2_r;
    m1_nxt    = m1_r;
    m2_nxt    = m2_r;
    d1_nxt    = d1_r;
    d2_nxt    = d2_r;
    w_nxt     = w_r;
    p_nxt     = p_r;
    lo_nxt    = lo_r;
    t_nxt     = t_r;
    s11_nxt   = s11_r;
    s22_nxt   = s22_r;
    s12_nxt   = s12_r;
    sq_v_nxt  = sq_v_r;
    sq_res_nxt = sq_res_r;
    sq_bit_nxt = sq_bit_r;
    sq_k_nxt  = sq_k_r;
    ka_nxt    = ka_r;
    kb_nxt    = kb_r;
    sq_sel_nxt = sq_sel_r;
    sq1_nxt   = sq1_r;
    sq2_nxt   = sq2_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    q_nxt     = q_r;
    sat_nxt   = sat_r;
    neg_nxt   = neg_r;
    dcnt_nxt  = dcnt_r;
    corr_nxt  = corr_r;
    rvalid_nxt = rvalid_r;
    case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (store_ok) begin
            cnt_nxt = cnt_r + 1'b1;
            if (in_sample_weight != '0) begin
              used_nxt = used_r + 1'b1;
              wsum_nxt = wsum_r + {11'b0, in_sample_weight};
              s1_nxt   = s1_r + {{10{wp1[32]}}, wp1};
              s2_nxt   = s2_r + {{10{wp2[32]}}, wp2};
            end
          end
          if (in_last_pair) state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if ((used_r < CNT_W'(2)) || (wsum_r == '0)) begin
          corr_nxt   = '0;
          rvalid_nxt = 1'b0;
          state_nxt  = S_OUT;
        end else begin
          phase_nxt = PH_M1;
          dvd_nxt   = {15'b0, mag1};
          neg_nxt   = mn1[48];
          den_nxt   = {34'b0, wsum_r, 1'b0};
          rem_nxt   = '0;
          q_nxt     = '0;
          sat_nxt   = 1'b0;
          dcnt_nxt  = 8'd64;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        dvd_nxt  = {dvd_r[62:0], 1'b0};
        rem_nxt  = dge ? (rem_sh - {2'b0, den_r}) : rem_sh;
        sat_nxt  = sat_r | q_r[21];
        q_nxt    = {q_r[20:0], dge};
        dcnt_nxt = dcnt_r - 1'b1;
        if (dcnt_r == 8'd1) state_nxt = S_DIVEND;
      end
      S_DIVEND: begin
        case (phase_r)
          PH_M1: begin
            m1_nxt    = mval[20:0];
            phase_nxt = PH_M2;
            dvd_nxt   = {15'b0, mag2};
            neg_nxt   = mn2[48];
            rem_nxt   = '0;
            q_nxt     = '0;
            sat_nxt   = 1'b0;
            dcnt_nxt  = 8'd64;
            state_nxt = S_DIV;
          end
          PH_M2: begin
            m2_nxt    = mval[20:0];
            idx_nxt   = '0;
            term_nxt  = T_S11;
            s11_nxt   = '0;
            s22_nxt   = '0;
            s12_nxt   = '0;
            state_nxt = S_RD;
          end
          default: begin
            corr_nxt   = neg_r ? -$signed(cmag) : $signed(cmag);
            rvalid_nxt = 1'b1;
            state_nxt  = S_OUT;
          end
        endcase
      end
      S_RD: begin
        state_nxt = S_RDW;
      end
      S_RDW: begin
        d1_nxt    = 22'($signed({rd_data_r[47:32], 4'b0})) - 22'(m1_r);
        d2_nxt    = 22'($signed({rd_data_r[31:16], 4'b0})) - 22'(m2_r);
        w_nxt     = rd_data_r[15:0];
        term_nxt  = T_S11;
        state_nxt = S_MA;
      end
      S_MA: begin
        p_nxt     = prod[43:0];
        state_nxt = S_MB;
      end
      S_MB: begin
        lo_nxt    = prod[37:0];
        state_nxt = S_MC;
      end
      S_MC: begin
        t_nxt     = $signed({prod[37:0], 22'b0}) + $signed({22'b0, lo_r});
        state_nxt = S_MD;
      end
      S_MD: begin
        case (term_r)
          T_S11: begin
            s11_nxt   = s11_r + (t_r >>> TERM_SHIFT);
            term_nxt  = T_S22;
            state_nxt = S_MA;
          end
          T_S22: begin
            s22_nxt   = s22_r + (t_r >>> TERM_SHIFT);
            term_nxt  = T_S12;
            state_nxt = S_MA;
          end
          default: begin
            s12_nxt = s12_r + (t_r >>> TERM_SHIFT);
            idx_nxt = idx_r + 1'b1;
            if ((idx_r + 1'b1) == cnt_r) state_nxt = S_FIN;
            else state_nxt = S_RD;
          end
        endcase
      end
      S_FIN: begin
        if ((s11_r <= 0) || (s22_r <= 0)) begin
          corr_nxt   = '0;
          rvalid_nxt = 1'b0;
          state_nxt  = S_OUT;
        end else begin
          sq_v_nxt   = s11_r[61:0];
          sq_k_nxt   = '0;
          sq_sel_nxt = 1'b0;
          state_nxt  = S_NRM;
        end
      end
      S_NRM: begin
        if (sq_v_r[61:60] == 2'b00) begin
          sq_v_nxt = {sq_v_r[59:0], 2'b00};
          sq_k_nxt = sq_k_r + 1'b1;
        end else begin
          sq_bit_nxt = {1'b1, 60'b0};
          sq_res_nxt = '0;
          state_nxt  = S_SQ;
        end
      end
      S_SQ: begin
        if (sq_ge) begin
          sq_v_nxt   = sq_v_r - sq_sum[61:0];
          sq_res_nxt = (sq_res_r >> 1) + {1'b0, sq_bit_r};
        end else begin
          sq_res_nxt = sq_res_r >> 1;
        end
        sq_bit_nxt = sq_bit_r >> 2;
        if (sq_bit_r[0]) begin
          if (!sq_sel_r) begin
            sq1_nxt    = sq_res_nxt[30:0];
            ka_nxt     = sq_k_r;
            sq_v_nxt   = s22_r[61:0];
            sq_k_nxt   = '0;
            sq_sel_nxt = 1'b1;
            state_nxt  = S_NRM;
          end else begin
            sq2_nxt   = sq_res_nxt[30:0];
            kb_nxt    = sq_k_r;
            state_nxt = S_DEN;
          end
        end
      end
      S_DEN: begin
        den_nxt   = prod[61:0];
        phase_nxt = PH_COR;
        dvd_nxt   = {4'b0, s12_mag};
        neg_nxt   = s12_r[59];
        rem_nxt   = '0;
        q_nxt     = '0;
        sat_nxt   = 1'b0;
        dcnt_nxt  = 8'd64 + {1'b0, e_ext};
        state_nxt = S_DIV;
      end
      S_OUT: begin
        if (out_ready) begin
          cnt_nxt   = '0;
          used_nxt  = '0;
          wsum_nxt  = '0;
          s1_nxt    = '0;
          s2_nxt    = '0;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && store_ok) begin
      mem[cnt_r[ADDR_W-1:0]] <= {in_first_value, in_second_value, in_sample_weight};
    end
    rd_data_r <= mem[idx_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      used_r  <= '0;
      wsum_r  <= '0;
      s1_r    <= '0;
      s2_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      used_r  <= used_nxt;
      wsum_r  <= wsum_nxt;
      s1_r    <= s1_nxt;
      s2_r    <= s2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r  <= phase_nxt;
    term_r   <= term_nxt;
    idx_r    <= idx_nxt;
    m1_r     <= m1_nxt;
    m2_r     <= m2_nxt;
    d1_r     <= d1_nxt;
    d2_r     <= d2_nxt;
    w_r      <= w_nxt;
    p_r      <= p_nxt;
    lo_r     <= lo_nxt;
    t_r      <= t_nxt;
    s11_r    <= s11_nxt;
    s22_r    <= s22_nxt;
    s12_r    <= s12_nxt;
    sq_v_r   <= sq_v_nxt;
    sq_res_r <= sq_res_nxt;
    sq_bit_r <= sq_bit_nxt;
    sq_k_r   <= sq_k_nxt;
    ka_r     <= ka_nxt;
    kb_r     <= kb_nxt;
    sq_sel_r <= sq_sel_nxt;
    sq1_r    <= sq1_nxt;
    sq2_r    <= sq2_nxt;
    dvd_r    <= dvd_nxt;
    rem_r    <= rem_nxt;
    den_r    <= den_nxt;
    q_r      <= q_nxt;
    sat_r    <= sat_nxt;
    neg_r    <= neg_nxt;
    dcnt_r   <= dcnt_nxt;
    corr_r   <= corr_nxt;
    rvalid_r <= rvalid_nxt;
  end

  `WCC_ASSERT_NOW(a_not_both, in_ready, !out_valid, "load and result phases overlap")
  `WCC_ASSERT_NEXT(a_last_busy, accept && in_last_pair, !in_ready, "still ready after last item")
  `WCC_ASSERT_NOW(a_invalid_zero, out_valid && !out_result_valid, out_correlation == '0,
    "invalid result with nonzero correlation")
  `WCC_ASSERT_NOW(a_clamp, out_valid, (out_correlation <= $signed(CLAMP_Q14)) &&
    (out_correlation >= -$signed(CLAMP_Q14)), "correlation outside clamp")

endmodule
